// ===== sv/ngf_pkg.sv =====
// shared types, constants and byte folding for the n-gram line matcher
`default_nettype none

package ngf_pkg;

    // pattern register storage and padded view of the folded pattern
    localparam int PAT_BYTES = 24;
    localparam int PAT_PAD   = PAT_BYTES + 4;

    localparam logic [7:0] SPACE = 8'h20;

    // pattern length from which the second gram size is five
    localparam int LONG_PAT = 7;

    // gram sizes, sized for compares against a 6-bit length
    localparam logic [5:0] TRI_N   = 6'd3;
    localparam logic [5:0] SHORT_N = 6'd2;
    localparam logic [5:0] LONG_N  = 6'd5;

    localparam logic [15:0] LIMIT_MIN = 16'd3;

    // register indexes, byte address is 8 * index
    localparam logic [2:0] REG_PAT_LO   = 3'd0;
    localparam logic [2:0] REG_PAT_MID  = 3'd1;
    localparam logic [2:0] REG_PAT_HIGH = 3'd2;
    localparam logic [2:0] REG_PAT_LEN  = 3'd3;
    localparam logic [2:0] REG_THRESH   = 3'd4;
    localparam logic [2:0] REG_LIMIT    = 3'd5;

    typedef struct packed {
        logic [PAT_PAD-1:0][7:0] pat;    // folded, space past the pattern storage
        logic [4:0]              len;    // clamped pattern length
        logic                    long5;  // second gram size is five
        logic [6:0]              thr;
        logic [15:0]             lim_m1; // clamped line limit minus one
    } cfg_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b < 8'h30) begin
            r = SPACE;
        end else if (b inside {[8'h41:8'h5A]}) begin
            r = b + 8'h20;
        end else begin
            case (b)
                8'd196: r = 8'd228;
                8'd214: r = 8'd246;
                8'd220: r = 8'd252;
                8'd142: r = 8'd132;
                8'd153: r = 8'd148;
                8'd154: r = 8'd129;
                8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5D: r = SPACE;
                default: r = b;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ngram_fuzzy_line_matcher_top.sv =====
// n-gram fuzzy line matcher: top level
//
// Text arrives one byte per word on the s_ channel (s_text_byte, with
// s_line_end on the last byte of a line). Every byte is folded to lower
// case and spaces, shifted into a five character window and compared in
// parallel against all pattern trigrams and second grams.
// The m_ channel carries one word per line, on its last byte: hit,
// matched and maximum weights and the line too long flag.
// Throughput is one byte per clock while s_ready is high, lines back to
// back with no gap. From the line end byte accepted to m_valid a line
// result passes the input register, line record, gram counts, weights,
// then the output register with the threshold compare.
// When the receiver stalls, the result pipeline holds up to four line
// results; once it is full a line end byte waits in the input register and
// s_ready drops, while bytes inside a line keep flowing.
// Registers (APB, 64-bit, address 8*index) are to be written between lines
// by the user, which the block does not enforce; the count masks are
// registered from them. Reset (aresetn low, synchronous) restores register
// defaults, clears the window and gram found bits and empties the pipeline.
`default_nettype none

module ngram_fuzzy_line_matcher_top
    import ngf_pkg::*;
#(
    parameter int MAX_PATTERN = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_line_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic [7:0]       m_matched_weight,
    output logic [7:0]       m_max_weight,
    output logic             m_line_too_long
);

    cfg_t                   cfg;
    logic [MAX_PATTERN-3:0] tri_mask;
    logic [MAX_PATTERN-2:0] sec_mask;
    logic                   line_valid;
    logic                   line_free;
    logic [MAX_PATTERN-3:0] line_tri;
    logic [MAX_PATTERN-2:0] line_sec;
    logic                   line_long;

    ngf_config #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_config (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .tri_mask (tri_mask),
        .sec_mask (sec_mask)
    );

    ngf_scan #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .s_line_end  (s_line_end),
        .cfg         (cfg),
        .line_free   (line_free),
        .line_valid  (line_valid),
        .line_tri    (line_tri),
        .line_sec    (line_sec),
        .line_long   (line_long)
    );

    ngf_weigh #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_weigh (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .tri_mask         (tri_mask),
        .sec_mask         (sec_mask),
        .line_valid       (line_valid),
        .line_free        (line_free),
        .line_tri         (line_tri),
        .line_sec         (line_sec),
        .line_long        (line_long),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_matched_weight (m_matched_weight),
        .m_max_weight     (m_max_weight),
        .m_line_too_long  (m_line_too_long)
    );

endmodule

`default_nettype wire

// ===== sv/ngf_config.sv =====
// configuration registers, folded pattern and precomputed gram count masks
`default_nettype none

module ngf_config
    import ngf_pkg::*;
#(
    parameter int MAX_PATTERN = 24
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [5:0]             paddr,
    input  wire logic [63:0]            pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    output cfg_t                        cfg,
    output logic [MAX_PATTERN-3:0]      tri_mask,
    output logic [MAX_PATTERN-2:0]      sec_mask
);

    localparam int NT    = MAX_PATTERN - 2;
    localparam int NS    = MAX_PATTERN - 1;
    localparam int NG5   = (MAX_PATTERN >= LONG_PAT) ? MAX_PATTERN - 4 : 1;
    localparam int SPLIT = (NG5 + 1) / 2;

    logic [63:0] pat_lo_reg;
    logic [63:0] pat_mid_reg;
    logic [63:0] pat_high_reg;
    logic [4:0]  len_reg;
    logic [6:0]  thr_reg;
    logic [15:0] limit_reg;

    logic [PAT_BYTES*8-1:0]  raw;
    logic [PAT_PAD-1:0][7:0] pat;
    logic [4:0]              len_eff;
    logic [5:0]              len6;
    logic                    long5;
    logic [NG5-1:0]          trig5;

    logic [NT-1:0]  tri_mask_next, tri_mask_reg;
    logic [NG5-1:0] m5_lo_next, m5_lo_reg;
    logic [1:0]     skip1, carry_reg;
    logic [1:0]     skip2;
    logic [NG5-1:0] m5;
    logic [NS-1:0]  m5_ext;
    logic [NS-1:0]  sec_mask_next, sec_mask_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg   <= '0;
            pat_mid_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= 5'd0;
            thr_reg      <= 7'd50;
            limit_reg    <= 16'd1024;
        end else if (psel && penable && pwrite) begin
            case (paddr[5:3])
                REG_PAT_LO:   pat_lo_reg   <= pwdata;
                REG_PAT_MID:  pat_mid_reg  <= pwdata;
                REG_PAT_HIGH: pat_high_reg <= pwdata;
                REG_PAT_LEN:  len_reg      <= pwdata[4:0];
                REG_THRESH:   thr_reg      <= pwdata[6:0];
                REG_LIMIT:    limit_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_PAT_LO:   prdata = pat_lo_reg;
            REG_PAT_MID:  prdata = pat_mid_reg;
            REG_PAT_HIGH: prdata = pat_high_reg;
            REG_PAT_LEN:  prdata = 64'(len_reg);
            REG_THRESH:   prdata = 64'(thr_reg);
            REG_LIMIT:    prdata = 64'(limit_reg);
            default:      prdata = '0;
        endcase
    end

    assign raw = {pat_high_reg, pat_mid_reg, pat_lo_reg};

    for (genvar k = 0; k < PAT_PAD; k++) begin : g_pat
        if (k < MAX_PATTERN) begin : g_used
            assign pat[k] = fold_byte(raw[8*k +: 8]);
        end else begin : g_pad
            assign pat[k] = SPACE;
        end
    end

    assign len_eff = (len_reg > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : len_reg;
    assign len6    = {1'b0, len_eff};
    assign long5   = (len_eff >= 5'(LONG_PAT));

    always_comb begin
        cfg.pat    = pat;
        cfg.len    = len_eff;
        cfg.long5  = long5;
        cfg.thr    = thr_reg;
        cfg.lim_m1 = ((limit_reg < LIMIT_MIN) ? LIMIT_MIN : limit_reg) - 16'd1;
    end

    // a five gram whose fourth byte is space while its first is not starts a skip
    always_comb begin
        for (int i = 0; i < NG5; i++) begin
            trig5[i] = (pat[i+3] == SPACE) && (pat[i] != SPACE);
        end
    end

    // first half of the skip chain plus the trigram mask
    always_comb begin
        skip1 = 2'd0;
        for (int i = 0; i < NT; i++) begin
            tri_mask_next[i] = (6'(i) + TRI_N <= len6) &&
                               !((pat[i+1] == SPACE) && (pat[i] != SPACE));
        end
        m5_lo_next = '0;
        for (int i = 0; i < SPLIT; i++) begin
            if (skip1 != 2'd0) begin
                skip1 = skip1 - 2'd1;
            end else if (trig5[i]) begin
                skip1 = 2'd2;
            end else begin
                m5_lo_next[i] = 1'b1;
            end
        end
    end

    // second half of the chain, then the second gram mask for either size
    always_comb begin
        skip2 = carry_reg;
        m5    = m5_lo_reg;
        for (int i = SPLIT; i < NG5; i++) begin
            if (skip2 != 2'd0) begin
                m5[i] = 1'b0;
                skip2 = skip2 - 2'd1;
            end else if (trig5[i]) begin
                m5[i] = 1'b0;
                skip2 = 2'd2;
            end else begin
                m5[i] = 1'b1;
            end
        end
        m5_ext = NS'(m5);
        for (int i = 0; i < NS; i++) begin
            if (long5) begin
                sec_mask_next[i] = m5_ext[i] && (6'(i) + LONG_N <= len6);
            end else begin
                sec_mask_next[i] = (6'(i) + SHORT_N <= len6);
            end
        end
    end

    always_ff @(posedge aclk) begin
        tri_mask_reg <= tri_mask_next;
        m5_lo_reg    <= m5_lo_next;
        carry_reg    <= skip1;
        sec_mask_reg <= sec_mask_next;
    end

    assign tri_mask = tri_mask_reg;
    assign sec_mask = sec_mask_reg;

endmodule

`default_nettype wire

// ===== sv/ngf_scan.sv =====
// input register, character window and per-byte gram comparators
`default_nettype none

module ngf_scan
    import ngf_pkg::*;
#(
    parameter int MAX_PATTERN = 24
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_text_byte,
    input  wire logic                   s_line_end,
    input  cfg_t                        cfg,
    input  wire logic                   line_free,
    output logic                        line_valid,
    output logic [MAX_PATTERN-3:0]      line_tri,
    output logic [MAX_PATTERN-2:0]      line_sec,
    output logic                        line_long
);

    localparam int NT = MAX_PATTERN - 2;
    localparam int NS = MAX_PATTERN - 1;

    logic        in_v_reg;
    logic [7:0]  in_byte_reg;
    logic        in_le_reg;
    logic        in_go;

    logic [39:0]   window_reg;
    logic [15:0]   count_reg;
    logic [NT-1:0] tri_found_reg;
    logic [NS-1:0] sec_found_reg;

    logic [7:0]    c;
    logic [39:0]   win_next;
    logic [15:0]   cnt_next;
    logic [5:0]    len6;
    logic [NT-1:0] hit3;
    logic [NS-1:0] hitn;

    logic          line_v_reg;
    logic [NT-1:0] line_tri_reg;
    logic [NS-1:0] line_sec_reg;
    logic          line_long_reg;

    // a line end word waits here until the line record slot is free
    assign in_go   = in_v_reg && (!in_le_reg || line_free);
    assign s_ready = !in_v_reg || in_go;

    always_comb begin
        c        = fold_byte(in_byte_reg);
        win_next = {window_reg[31:0], c};
        cnt_next = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
        len6     = {1'b0, cfg.len};
        for (int i = 0; i < NT; i++) begin
            hit3[i] = (cnt_next >= 16'(TRI_N)) && (6'(i) + TRI_N <= len6) &&
                      (cfg.pat[i]   == win_next[23:16]) &&
                      (cfg.pat[i+1] == win_next[15:8]) &&
                      (cfg.pat[i+2] == win_next[7:0]);
        end
        for (int i = 0; i < NS; i++) begin
            if (cfg.long5) begin
                hitn[i] = (cnt_next >= 16'(LONG_N)) && (6'(i) + LONG_N <= len6) &&
                          (cfg.pat[i]   == win_next[39:32]) &&
                          (cfg.pat[i+1] == win_next[31:24]) &&
                          (cfg.pat[i+2] == win_next[23:16]) &&
                          (cfg.pat[i+3] == win_next[15:8]) &&
                          (cfg.pat[i+4] == win_next[7:0]);
            end else begin
                hitn[i] = (cnt_next >= 16'(SHORT_N)) && (6'(i) + SHORT_N <= len6) &&
                          (cfg.pat[i]   == win_next[15:8]) &&
                          (cfg.pat[i+1] == win_next[7:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg      <= 1'b0;
            window_reg    <= {5{SPACE}};
            count_reg     <= 16'd1;
            tri_found_reg <= '0;
            sec_found_reg <= '0;
            line_v_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                in_v_reg <= s_valid;
            end
            if (in_go) begin
                if (in_le_reg) begin
                    window_reg    <= {5{SPACE}};
                    count_reg     <= 16'd1;
                    tri_found_reg <= '0;
                    sec_found_reg <= '0;
                end else begin
                    window_reg    <= win_next;
                    count_reg     <= cnt_next;
                    tri_found_reg <= tri_found_reg | hit3;
                    sec_found_reg <= sec_found_reg | hitn;
                end
            end
            if (line_free) begin
                line_v_reg <= in_go && in_le_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_le_reg   <= s_line_end;
        end
        if (in_go && in_le_reg) begin
            line_tri_reg  <= tri_found_reg | hit3;
            line_sec_reg  <= sec_found_reg | hitn;
            line_long_reg <= (cnt_next >= cfg.lim_m1);
        end
    end

    assign line_valid = line_v_reg;
    assign line_tri   = line_tri_reg;
    assign line_sec   = line_sec_reg;
    assign line_long  = line_long_reg;

endmodule

`default_nettype wire

// ===== sv/ngf_weigh.sv =====
// line result pipeline: counts, weights, threshold compare and output register
`default_nettype none

module ngf_weigh
    import ngf_pkg::*;
#(
    parameter int MAX_PATTERN = 24
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  cfg_t                        cfg,
    input  wire logic [MAX_PATTERN-3:0] tri_mask,
    input  wire logic [MAX_PATTERN-2:0] sec_mask,
    input  wire logic                   line_valid,
    output logic                        line_free,
    input  wire logic [MAX_PATTERN-3:0] line_tri,
    input  wire logic [MAX_PATTERN-2:0] line_sec,
    input  wire logic                   line_long,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_hit,
    output logic [7:0]                  m_matched_weight,
    output logic [7:0]                  m_max_weight,
    output logic                        m_line_too_long
);

    localparam int CW = $clog2(MAX_PATTERN);

    logic          out_free, r3_free, r2_free;

    logic          r2_v_reg;
    logic [CW-1:0] tm_reg, tx_reg, sm_reg, sx_reg;
    logic          r2_long_reg;

    logic          r3_v_reg;
    logic [7:0]    mw_reg, xw_reg;
    logic          r3_long_reg;
    logic [7:0]    mw_next, xw_next;

    logic          out_v_reg;
    logic          hit_reg;
    logic [7:0]    out_mw_reg, out_xw_reg;
    logic          out_long_reg;
    logic [14:0]   prod_m, prod_x;
    logic          hit_next;

    assign out_free  = !out_v_reg || m_ready;
    assign r3_free   = !r3_v_reg || out_free;
    assign r2_free   = !r2_v_reg || r3_free;
    assign line_free = !line_valid || r2_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r2_v_reg  <= 1'b0;
            r3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (r2_free) begin
                r2_v_reg <= line_valid;
            end
            if (r3_free) begin
                r3_v_reg <= r2_v_reg;
            end
            if (out_free) begin
                out_v_reg <= r3_v_reg;
            end
        end
    end

    // weights: three per trigram, two or five per second gram
    always_comb begin
        if (cfg.long5) begin
            mw_next = 8'({tm_reg, 1'b0}) + 8'(tm_reg) + 8'({sm_reg, 2'b00}) + 8'(sm_reg);
            xw_next = 8'({tx_reg, 1'b0}) + 8'(tx_reg) + 8'({sx_reg, 2'b00}) + 8'(sx_reg);
        end else begin
            mw_next = 8'({tm_reg, 1'b0}) + 8'(tm_reg) + 8'({sm_reg, 1'b0});
            xw_next = 8'({tx_reg, 1'b0}) + 8'(tx_reg) + 8'({sx_reg, 1'b0});
        end
    end

    assign prod_m   = 15'(mw_reg) * 15'd100;
    assign prod_x   = 15'(cfg.thr) * 15'(xw_reg);
    assign hit_next = (xw_reg != 8'd0) && (prod_m >= prod_x);

    always_ff @(posedge aclk) begin
        if (r2_free) begin
            tm_reg      <= CW'($countones(line_tri & tri_mask));
            tx_reg      <= CW'($countones(tri_mask));
            sm_reg      <= CW'($countones(line_sec & sec_mask));
            sx_reg      <= CW'($countones(sec_mask));
            r2_long_reg <= line_long;
        end
        if (r3_free) begin
            mw_reg      <= mw_next;
            xw_reg      <= xw_next;
            r3_long_reg <= r2_long_reg;
        end
        if (out_free) begin
            // an overlong line reports nothing but the error flag
            hit_reg      <= hit_next && !r3_long_reg;
            out_mw_reg   <= r3_long_reg ? 8'd0 : mw_reg;
            out_xw_reg   <= r3_long_reg ? 8'd0 : xw_reg;
            out_long_reg <= r3_long_reg;
        end
    end

    assign m_valid          = out_v_reg;
    assign m_hit            = hit_reg;
    assign m_matched_weight = out_mw_reg;
    assign m_max_weight     = out_xw_reg;
    assign m_line_too_long  = out_long_reg;

endmodule

`default_nettype wire

// ===== sv/ngf_checker.sv =====
// port level checks on the result channel, bound to the top level
`default_nettype none

module ngf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_hit,
    input wire logic [7:0] m_matched_weight,
    input wire logic [7:0] m_max_weight,
    input wire logic       m_line_too_long
);

    // a stalled word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) &&
        $stable(m_matched_weight) && $stable(m_max_weight) && $stable(m_line_too_long))
        else $error("result word changed while stalled");

    // reset empties the result pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_long_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_too_long |->
        !m_hit && (m_matched_weight == 8'd0) && (m_max_weight == 8'd0))
        else $error("overlong line with nonzero result");

    a_hit_needs_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> (m_max_weight != 8'd0))
        else $error("hit with zero max weight");

    a_matched_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_matched_weight <= m_max_weight))
        else $error("matched weight above max weight");

endmodule

bind ngram_fuzzy_line_matcher_top ngf_checker u_checker (.*);

`default_nettype wire

// ===== test/ngf_line_checker.sv =====
// line result checker: mirrors register writes, predicts each line's weights and compares
`timescale 1ns / 100ps

module ngf_line_checker
    import ngf_pkg::*;
#(
    parameter int MAX_PATTERN = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_line_end,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_hit,
    input  wire logic [7:0]  m_matched_weight,
    input  wire logic [7:0]  m_max_weight,
    input  wire logic        m_line_too_long,
    output int unsigned      errors,
    output int unsigned      pending,
    output int unsigned      lines_seen,
    output int unsigned      hits_seen,
    output int unsigned      long_seen
);

    typedef struct packed {
        logic       hit;
        logic [7:0] matched;
        logic [7:0] maxw;
        logic       too_long;
    } line_result_t;

    // register copies
    logic [63:0] pat_word [3];
    logic [4:0]  pat_len;
    logic [6:0]  thr_pct;
    logic [15:0] line_lim;

    // state of the line in progress
    logic [39:0] window;
    logic [15:0] line_count;
    logic [21:0] tri_found;
    logic [22:0] sec_found;

    line_result_t expected_lines[$];

    function automatic logic [7:0] fold_text_byte(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'd196: r = 8'd228;
            8'd214: r = 8'd246;
            8'd220: r = 8'd252;
            8'd142: r = 8'd132;
            8'd153: r = 8'd148;
            8'd154: r = 8'd129;
            8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5D: r = SPACE;
            default: begin
                if (b < 8'h30) begin
                    r = SPACE;
                end else if (b >= 8'h41 && b <= 8'h5A) begin
                    r = b | 8'h20;
                end else begin
                    r = b;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pattern_char(input int i);
        if (i >= MAX_PATTERN || i >= PAT_BYTES) return SPACE;
        return fold_text_byte(pat_word[i / 8][(i % 8) * 8 +: 8]);
    endfunction

    function automatic int active_len();
        return (int'(pat_len) > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    endfunction

    // gram of size k at pattern position pos against the newest k window chars
    function automatic bit gram_in_window(input int pos, input int k);
        int j;
        if (int'(line_count) < k) return 1'b0;
        for (j = 0; j < k; j++) begin
            if (pattern_char(pos + j) != window[8 * (k - 1 - j) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic weigh_grams(input logic [22:0] found, input int plen, input int n,
                               inout int matched, inout int maxw);
        int i;
        if (plen < n) return;
        i = 0;
        while (i < plen - n + 1) begin
            if (n >= 3 && pattern_char(i + n - 2) == SPACE && pattern_char(i) != SPACE) begin
                // gram broken by a space: drop it and the n-3 grams after it
                i += n - 2;
            end else begin
                maxw += n;
                if (found[i]) matched += n;
                i++;
            end
        end
    endtask

    task automatic clear_line();
        window     = {5{SPACE}};
        line_count = 16'd1;
        tri_found  = '0;
        sec_found  = '0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        case (idx)
            REG_PAT_LO:   pat_word[0] = value;
            REG_PAT_MID:  pat_word[1] = value;
            REG_PAT_HIGH: pat_word[2] = value;
            REG_PAT_LEN:  pat_len = value[4:0];
            REG_THRESH:   thr_pct = value[6:0];
            REG_LIMIT:    line_lim = value[15:0];
            default: ;
        endcase
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        int plen, n2, i, matched, maxw, lim;
        line_result_t res;
        window = {window[31:0], fold_text_byte(b)};
        if (line_count != 16'hFFFF) line_count++;
        plen = active_len();
        n2 = (plen < LONG_PAT) ? int'(SHORT_N) : int'(LONG_N);
        for (i = 0; i + 3 <= plen && i < 22; i++) begin
            if (gram_in_window(i, int'(TRI_N))) tri_found[i] = 1'b1;
        end
        for (i = 0; i + n2 <= plen && i < 23; i++) begin
            if (gram_in_window(i, n2)) sec_found[i] = 1'b1;
        end
        if (!last) return;
        res = '0;
        lim = (line_lim < LIMIT_MIN) ? int'(LIMIT_MIN) : int'(line_lim);
        if (int'(line_count) - 1 >= lim - 2) begin
            res.too_long = 1'b1;
        end else begin
            matched = 0;
            maxw = 0;
            weigh_grams({1'b0, tri_found}, plen, int'(TRI_N), matched, maxw);
            weigh_grams(sec_found, plen, n2, matched, maxw);
            res.hit     = (maxw > 0 && 100 * matched >= int'(thr_pct) * maxw);
            res.matched = matched[7:0];
            res.maxw    = maxw[7:0];
        end
        expected_lines.push_back(res);
        clear_line();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        line_result_t want;
        if (!aresetn) begin
            pat_word[0] = '0;
            pat_word[1] = '0;
            pat_word[2] = '0;
            pat_len     = '0;
            thr_pct     = 7'd50;
            line_lim    = 16'd1024;
            clear_line();
            expected_lines.delete();
            errors     = 0;
            lines_seen = 0;
            hits_seen  = 0;
            long_seen  = 0;
        end else begin
            if (psel && penable && pwrite && pready) write_reg(paddr[5:3], pwdata);
            if (s_valid && s_ready) take_byte(s_text_byte, s_line_end);
            if (m_valid && m_ready) begin
                lines_seen++;
                if (m_hit) hits_seen++;
                if (m_line_too_long) long_seen++;
                if (expected_lines.size() == 0) begin
                    $error("result word with no line waiting for it");
                    errors++;
                end else begin
                    want = expected_lines.pop_front();
                    check_field("hit", want.hit, m_hit);
                    check_field("matched_weight", want.matched, m_matched_weight);
                    check_field("max_weight", want.maxw, m_max_weight);
                    check_field("line_too_long", want.too_long, m_line_too_long);
                end
            end
        end
        pending <= expected_lines.size();
    end

endmodule

// ===== test/tb_top.sv =====
// testbench top: clock, reset, register setup, text line stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
    import ngf_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int PHASE_BYTES = 75;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_text_byte;
    logic        s_line_end;
    logic        m_valid;
    logic        m_ready;
    logic        m_hit;
    logic [7:0]  m_matched_weight;
    logic [7:0]  m_max_weight;
    logic        m_line_too_long;

    int unsigned errors;
    int unsigned pending;
    int unsigned lines_seen;
    int unsigned hits_seen;
    int unsigned long_seen;

    logic [63:0] next_pat [3];
    logic [7:0]  pat_raw [PAT_BYTES];
    int          pat_used;
    bit          steady;
    int unsigned bytes_sent;
    int unsigned settings;
    int          stall_left;

    ngram_fuzzy_line_matcher_top i_dut (.*);

    ngf_line_checker i_checker (.*);

    initial aclk = 1'b0;
    always #(CLK_HALF) aclk = ~aclk;

    // run guard
    initial begin
        #(8_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: short random stalls, now and then a long one to fill the pipeline
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
            m_ready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 499) == 0) begin
            stall_left <= 20;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 10);
        end
    end

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(input int len, input int thr, input int lim);
        int i;
        drain_results();
        reg_write(REG_PAT_LO, next_pat[0]);
        reg_write(REG_PAT_MID, next_pat[1]);
        reg_write(REG_PAT_HIGH, next_pat[2]);
        reg_write(REG_PAT_LEN, 64'(len));
        reg_write(REG_THRESH, 64'(thr));
        reg_write(REG_LIMIT, 64'(lim));
        for (i = 0; i < PAT_BYTES; i++) pat_raw[i] = next_pat[i / 8][(i % 8) * 8 +: 8];
        pat_used = (len > PAT_BYTES) ? PAT_BYTES : len;
        settings++;
        repeat (4) @(posedge aclk);
    endtask

    task automatic make_pattern(input bit raw_bits);
        int i;
        logic [7:0] b;
        for (i = 0; i < PAT_BYTES; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2: b = SPACE;
                3, 4: begin
                    case ($urandom_range(0, 5))
                        0: b = 8'd196;
                        1: b = 8'd214;
                        2: b = 8'd220;
                        3: b = 8'd142;
                        4: b = 8'd153;
                        default: b = 8'd154;
                    endcase
                end
                5, 6: b = 8'($urandom_range(0, 255));
                // small alphabet so grams repeat
                default: b = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 5));
            endcase
            if (raw_bits) b = 8'($urandom_range(0, 255));
            next_pat[i / 8][(i % 8) * 8 +: 8] = b;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        s_line_end  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // text mostly copied from the pattern at random offsets, with noise
    task automatic send_line(input int nbytes);
        int k, cur, r;
        logic [7:0] b;
        cur = $urandom_range(0, PAT_BYTES - 1);
        for (k = 0; k < nbytes; k++) begin
            r = $urandom_range(0, 99);
            if (pat_used > 0 && r < 65) begin
                b = pat_raw[cur % pat_used];
                cur++;
                if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 1) == 1) begin
                    b = b ^ 8'h20;
                end
            end else if (r < 75) begin
                cur = $urandom_range(0, PAT_BYTES - 1);
                case ($urandom_range(0, 3))
                    0: b = SPACE;
                    1: b = 8'h00;
                    2: b = 8'h3A + 8'($urandom_range(0, 5));
                    default: b = 8'h5B;
                endcase
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            send_byte(b, k == nbytes - 1);
        end
    endtask

    initial begin
        int p, k, r, len, thr, lim, phase_start;
        bit paused;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        s_valid     <= 1'b0;
        s_text_byte <= '0;
        s_line_end  <= 1'b0;
        aresetn     <= 1'b0;
        steady      = 1'b0;
        paused      = 1'b0;
        pat_used    = 0;
        bytes_sent  = 0;
        settings    = 0;
        for (k = 0; k < PAT_BYTES; k++) pat_raw[k] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: empty pattern, nothing weighs
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h61, 1'b1);

        // short pattern with an umlaut, a zero byte and a space-broken trigram
        next_pat[0] = 64'h0000_5100_6573_C44B;
        next_pat[1] = '0;
        next_pat[2] = '0;
        load_config(6, 100, 1024);
        send_byte(8'h6B, 1'b0);
        send_byte(8'hE4, 1'b0);
        send_byte(8'h53, 1'b0);
        send_byte(8'h45, 1'b0);
        send_byte(8'h5B, 1'b0);
        send_byte(8'h71, 1'b0);
        send_byte(8'h0A, 1'b1);
        // zero threshold hits on any weighed line
        load_config(6, 0, 1024);
        send_byte(8'h99, 1'b1);

        // length above storage, limit below three: every line too long
        make_pattern(1'b1);
        load_config(31, 50, 1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h7A, 1'b1);
        send_byte(8'h30, 1'b1);

        // widest limit
        load_config(31, 50, 65535);
        for (k = 0; k < 8; k++) send_byte(pat_raw[k], 1'b0);
        send_byte(8'h0A, 1'b1);

        for (p = 0; p < 10; p++) begin
            case (p)
                0: len = 3;
                1: len = 5;
                2: len = 7;
                3: len = 12;
                4: len = 24;
                5: len = 28;
                6: len = 2;
                7: len = 6;
                8: len = 16;
                default: len = $urandom_range(0, 31);
            endcase
            case (p)
                3: thr = 100;
                7: thr = 0;
                0, 6, 9: thr = $urandom_range(0, 100);
                default: thr = $urandom_range(30, 80);
            endcase
            case (p)
                2: lim = 30;
                6: lim = 12;
                8: lim = 2;
                4: lim = 65535;
                default: lim = $urandom_range(200, 2000);
            endcase
            make_pattern(p == 9);
            load_config(len, thr, lim);
            steady = (p == 5);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if (p == 3 && !paused && bytes_sent - phase_start > 40) begin
                    // hold the sender until the pipeline is empty
                    drain_results();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    send_line($urandom_range(1, 3));
                end else if (r < 90) begin
                    send_line($urandom_range(4, 24));
                end else begin
                    send_line($urandom_range(25, 40));
                end
            end
            steady = 1'b0;
        end

        drain_results();
        $display("checked %0d line results (%0d hits, %0d too long) from %0d text bytes",
                 lines_seen, hits_seen, long_seen, bytes_sent);
        $display("%0d register settings: pattern lengths 0 to 31, limits 1 to 65535",
                 settings);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
